/* sv/csvfs_pkg.sv */
// shared types, constants and token functions for the csv field splitter
`default_nettype none
package csvfs_pkg;

    localparam int unsigned MAX_EV = 8;

    localparam logic [7:0] LF_BYTE = 8'd10;
    localparam logic [7:0] CR_BYTE = 8'd13;

    localparam logic [7:0] DELIM_RST = 8'd44;
    localparam logic [7:0] QUOTE_RST = 8'd34;
    localparam logic [7:0] ESC_RST   = 8'd92;

    // config register indexes
    localparam logic [1:0] REG_DELIM = 2'd0;
    localparam logic [1:0] REG_QUOTE = 2'd1;
    localparam logic [1:0] REG_ESC   = 2'd2;

    // event kinds
    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_FIELD = 3'd1;
    localparam logic [2:0] KIND_ROW   = 3'd2;
    localparam logic [2:0] KIND_OK    = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // byte classes
    localparam logic [2:0] CL_NL    = 3'd0;
    localparam logic [2:0] CL_QUOTE = 3'd1;
    localparam logic [2:0] CL_DELIM = 3'd2;
    localparam logic [2:0] CL_ESC   = 3'd3;
    localparam logic [2:0] CL_CHAR  = 3'd4;
    localparam logic [2:0] CL_WHITE = 3'd5;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] quote;
        logic [7:0] esc;
    } t_cfg;

    typedef struct packed {
        logic in_quotes;
        logic failed;
        logic field_has_bytes;
        logic row_has_fields;
        logic prior_allows_open;
        logic escape_waiting;
        logic cr_waiting;
    } t_state;

    localparam t_state STATE_RST = '{
        in_quotes: 1'b0, failed: 1'b0, field_has_bytes: 1'b0,
        row_has_fields: 1'b0, prior_allows_open: 1'b1,
        escape_waiting: 1'b0, cr_waiting: 1'b0
    };

    typedef struct packed {
        logic [7:0] fbyte;
        logic [2:0] kind;
    } t_event;

    typedef t_event [MAX_EV-1:0] t_ev_list;

    typedef struct packed {
        t_state     st;
        t_ev_list   ev;
        logic [3:0] n;
    } t_work;

    function automatic logic [2:0] classify(logic [7:0] b, t_cfg cfg);
        logic [2:0] c;
        if (b == LF_BYTE) begin
            c = CL_NL;
        end else begin
            if (b == cfg.quote)      c = CL_QUOTE;
            else if (b == cfg.delim) c = CL_DELIM;
            else if (b == cfg.esc)   c = CL_ESC;
            else                     c = CL_CHAR;
            if (b == 8'd9 || b == 8'd11 || b == 8'd12 || b == CR_BYTE || b == 8'd32)
                c = CL_WHITE;
        end
        return c;
    endfunction

    function automatic t_work emit(t_work w, logic [2:0] kind, logic [7:0] b);
        t_work r;
        r = w;
        if (r.n < 4'(MAX_EV)) begin
            r.ev[r.n[2:0]] = '{fbyte: b, kind: kind};
            r.n = r.n + 4'd1;
        end
        return r;
    endfunction

    // one folded byte through the field/row logic
    function automatic t_work token(t_work w, logic [7:0] b, t_cfg cfg);
        t_work      r;
        logic [2:0] c;
        logic       done;
        r    = w;
        c    = classify(b, cfg);
        done = r.st.failed;
        if (!done && r.st.escape_waiting) begin
            r.st.escape_waiting = 1'b0;
            if (c == CL_QUOTE) begin
                // escaped quote is a literal byte
                r = emit(r, KIND_BYTE, b);
                r.st.field_has_bytes   = 1'b1;
                r.st.prior_allows_open = 1'b0;
                done = 1'b1;
            end else begin
                r = emit(r, KIND_BYTE, cfg.esc);
                r.st.field_has_bytes = 1'b1;
            end
        end
        if (!done) begin
            case (c)
                CL_NL: begin
                    if (r.st.in_quotes) begin
                        r.st.failed = 1'b1;
                    end else begin
                        if (r.st.field_has_bytes) begin
                            r = emit(r, KIND_FIELD, 8'd0);
                            r.st.field_has_bytes = 1'b0;
                            r.st.row_has_fields  = 1'b1;
                        end
                        if (r.st.row_has_fields) begin
                            r = emit(r, KIND_ROW, 8'd0);
                            r.st.row_has_fields = 1'b0;
                        end
                        r.st.prior_allows_open = 1'b1;
                    end
                end
                CL_DELIM: begin
                    if (r.st.in_quotes) begin
                        r = emit(r, KIND_BYTE, b);
                        r.st.field_has_bytes = 1'b1;
                    end else begin
                        r = emit(r, KIND_FIELD, 8'd0);
                        r.st.field_has_bytes = 1'b0;
                        r.st.row_has_fields  = 1'b1;
                    end
                    r.st.prior_allows_open = 1'b1;
                end
                CL_ESC: begin
                    r.st.escape_waiting    = 1'b1;
                    r.st.prior_allows_open = 1'b0;
                end
                CL_CHAR: begin
                    r = emit(r, KIND_BYTE, b);
                    r.st.field_has_bytes   = 1'b1;
                    r.st.prior_allows_open = 1'b0;
                end
                CL_WHITE: begin
                    if (r.st.in_quotes) begin
                        r = emit(r, KIND_BYTE, b);
                        r.st.field_has_bytes = 1'b1;
                    end
                    r.st.prior_allows_open = 1'b1;
                end
                CL_QUOTE: begin
                    if (r.st.in_quotes) begin
                        r.st.in_quotes         = 1'b0;
                        r.st.prior_allows_open = 1'b0;
                    end else if (!r.st.prior_allows_open) begin
                        // quote opened in the middle of a field
                        r.st.failed    = 1'b1;
                        r.st.in_quotes = 1'b1;
                    end else begin
                        r.st.in_quotes         = 1'b1;
                        r.st.prior_allows_open = 1'b0;
                    end
                end
                default: begin
                    r = r;
                end
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/csvfs_step.sv */
// per-byte step: cr/lf folding, tokenizing and end-of-document handling
`default_nettype none
module csvfs_step (
    input  var csvfs_pkg::t_state   i_st,
    input  var csvfs_pkg::t_cfg     i_cfg,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output csvfs_pkg::t_state       o_st,
    output csvfs_pkg::t_ev_list     o_ev,
    output logic [3:0]              o_n
);
    import csvfs_pkg::*;

    t_work w;
    logic  folded;

    always_comb begin
        w.st   = i_st;
        w.ev   = '0;
        w.n    = 4'd0;
        folded = 1'b0;

        // a held cr resolves against this byte
        if (w.st.cr_waiting) begin
            w.st.cr_waiting = 1'b0;
            if (i_byte == LF_BYTE) begin
                w      = token(w, LF_BYTE, i_cfg);
                folded = 1'b1;
            end else begin
                w = token(w, CR_BYTE, i_cfg);
            end
        end
        if (!folded) begin
            if (i_byte == CR_BYTE) w.st.cr_waiting = 1'b1;
            else                   w = token(w, i_byte, i_cfg);
        end

        // end of document: flush cr, implied newline, verdict
        if (i_last) begin
            if (w.st.cr_waiting) begin
                w.st.cr_waiting = 1'b0;
                w = token(w, CR_BYTE, i_cfg);
            end
            w = token(w, LF_BYTE, i_cfg);
            w = emit(w, (w.st.failed || w.st.in_quotes) ? KIND_ERR : KIND_OK, 8'd0);
            w.st = STATE_RST;
        end

        o_st = w.st;
        o_ev = w.ev;
        o_n  = w.n;
    end

endmodule
`default_nettype wire

/* sv/csv_field_splitter_top.sv */
// top level of the csv field splitter: input register, step logic, event group queue
//
// usage
//   s_axis carries one document byte per transfer: tdata[7:0] is the byte,
//   tlast marks the last byte of a document (an implied newline and the
//   document verdict follow it).
//   m_axis carries one event per transfer: tdata[2:0] event kind, tdata[10:3]
//   the field byte (zero for other kinds); tlast is high on the final event
//   caused by one input byte.
//   the config port writes delimiter, quote and escape bytes by index; write
//   only while no document byte is in flight.
// timing
//   an accepted byte is held in the input register until the queue has room,
//   then its events (zero to eight) land as one group in the queue.
//   one byte per cycle is taken while the queue has room; events drain one
//   per cycle while m_axis_tready is high, and that drain sets the rate.
// reset and stall
//   reset empties the input register and queue, clears parser state and loads
//   the default config bytes. a stalled m_axis fills the queue, then tready on
//   s_axis drops; nothing is lost.
`default_nettype none
module csv_field_splitter_top #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_document
    // event stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [2:0] event_kind, [10:3] field_byte
    output logic             m_axis_tlast    // last_of_run
);
    import csvfs_pkg::*;

    localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    // config registers
    t_cfg r_cfg;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    t_state r_st;

    // event group queue
    t_ev_list          r_grp_ev [FIFO_DEPTH];
    logic [3:0]        r_grp_n  [FIFO_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_cnt;
    logic [2:0]        r_ev_idx;

    t_state     n_st;
    t_ev_list   step_ev;
    logic [3:0] step_n;

    logic   room;
    logic   consume;
    logic   push;
    logic   pop;
    logic   out_xfer;
    logic   in_xfer;
    t_event head_ev;
    logic   head_last;

    csvfs_step u_step (
        .i_st   (r_st),
        .i_cfg  (r_cfg),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_st   (n_st),
        .o_ev   (step_ev),
        .o_n    (step_n)
    );

    assign room    = (r_cnt != CW'(FIFO_DEPTH));
    assign consume = r_in_valid && room;
    assign push    = consume && (step_n != 4'd0);

    assign s_axis_tready = !r_in_valid || room;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // head of queue, one event per output cycle while m_axis_tready is high
    assign head_ev   = r_grp_ev[r_rd_ptr][r_ev_idx];
    assign head_last = ({1'b0, r_ev_idx} == (r_grp_n[r_rd_ptr] - 4'd1));

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {5'd0, head_ev};
    assign m_axis_tlast  = head_last;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign pop      = out_xfer && head_last;

    // config writes; unlisted index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{delim: DELIM_RST, quote: QUOTE_RST, esc: ESC_RST};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DELIM: r_cfg.delim <= i_cfg_data;
                REG_QUOTE: r_cfg.quote <= i_cfg_data;
                REG_ESC:   r_cfg.esc   <= i_cfg_data;
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parser state advances when the held byte moves into the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RST;
        end else if (consume) begin
            r_st <= n_st;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_grp_ev[r_wr_ptr] <= step_ev;
            r_grp_n[r_wr_ptr]  <= step_n;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_ev_idx <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
                r_ev_idx <= '0;
            end else if (out_xfer) begin
                r_ev_idx <= r_ev_idx + 3'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/csvfs_checker.sv */
// port-level checks on the csv field splitter event stream, bound to the top level
`default_nettype none
module csvfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    import csvfs_pkg::*;

    // stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("event changed while stalled");

    // nothing shown the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("event valid right after reset");

    // only known kinds, and field byte is zero for non-byte events
    a_kind_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == KIND_BYTE ||
            (m_axis_tdata[2:0] == KIND_FIELD || m_axis_tdata[2:0] == KIND_ROW ||
             m_axis_tdata[2:0] == KIND_OK || m_axis_tdata[2:0] == KIND_ERR) &&
            m_axis_tdata[10:3] == 8'd0) && m_axis_tdata[15:11] == 5'd0)
        else $error("bad event kind or payload");

    // a document verdict always ends its run
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == KIND_OK || m_axis_tdata[2:0] == KIND_ERR)
            |-> m_axis_tlast)
        else $error("document verdict not last of run");

endmodule

bind csv_field_splitter_top csvfs_checker u_csvfs_checker (.*);
`default_nettype wire
